>>> src/eihx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eihx_pkg;

  // Byte offsets within the frame
  localparam logic [15:0] POS_SRC_MAC = 16'd6;
  localparam logic [15:0] POS_ETYPE   = 16'd12;
  localparam logic [15:0] POS_IHL     = 16'd14;
  localparam logic [15:0] POS_PROTO   = 16'd23;
  localparam logic [15:0] POS_SRC_IP  = 16'd26;
  localparam logic [15:0] POS_DST_IP  = 16'd30;
  localparam logic [15:0] POS_IP_END  = 16'd34;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Result item: 243 bits of fields, padded to 31 bytes
  localparam int RESULT_BITS = 248;

  typedef enum logic [1:0] {
    L4_OTHER = 2'd0,
    L4_TCP   = 2'd1,
    L4_UDP   = 2'd2
  } l4_kind_t;

  // Header fields captured so far in the current frame
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [3:0]  header_words;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } frame_fields_t;

  localparam frame_fields_t FIELDS_CLEAR = '0;

endpackage

`default_nettype wire

>>> src/eth_ipv4_l4_header_extractor.sv
`timescale 1ns / 1ps
// m_tvalid on a frame's result rises in the cycle after the transfer of its last byte.
// Throughput: one byte per cycle while s_tready is high; a new frame may follow at once.
// s_tready drops only while a result sits unaccepted in the output register.
// Reset (rst, synchronous, active high) clears the frame capture state, the
// output valid flag, and sets the running minimum to 65535 and the maximum to 0.
`default_nettype none

module eth_ipv4_l4_header_extractor import eihx_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Byte stream in
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [7:0] frame_byte
  input  wire logic                   s_tlast,   // last_byte
  // Per-frame results out
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // From bit 0 up: dst_mac 48, src_mac 48, is_ipv4 1, src_ip 32, dst_ip 32,
  // l4_kind 2, src_port 16, dst_port 16, frame_length 16, min_length 16,
  // max_length 16, zero pad 5
  output logic [RESULT_BITS-1:0]      m_tdata
);

  logic          byte_take;
  logic          frame_done;
  frame_fields_t fields_next;
  logic [15:0]   len_next;

  // The output register frees up in the same cycle that its result is taken,
  // so a stall only arises when downstream is holding off.
  assign s_tready   = !m_tvalid || m_tready;
  assign byte_take  = s_tvalid && s_tready;
  assign frame_done = byte_take && s_tlast;

  // Header capture: position counter plus the field shift registers, updated
  // on every byte transfer and cleared after the last byte.
  eihx_capture #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk         (clk),
    .rst         (rst),
    .byte_take   (byte_take),
    .frame_byte  (s_tdata),
    .last_byte   (s_tlast),
    .fields_next (fields_next),
    .len_next    (len_next)
  );

  // Result build: classification, zeroing of absent fields, running
  // min/max, and the output register.
  eihx_result u_result (
    .clk        (clk),
    .rst        (rst),
    .frame_done (frame_done),
    .fields     (fields_next),
    .len        (len_next),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_data   (m_tdata)
  );

endmodule

`default_nettype wire

>>> src/eihx_capture.sv
`timescale 1ns / 1ps
`default_nettype none

module eihx_capture import eihx_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_take,
  input  wire logic [7:0]    frame_byte,
  input  wire logic          last_byte,
  output frame_fields_t      fields_next,
  output logic [15:0]        len_next
);

  localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);

  logic [15:0]   pos;
  frame_fields_t fields;

  logic [3:0]  ihl;
  logic [15:0] l4;
  logic        in_range;

  // Fields as they stand once this byte is taken in
  always_comb begin
    fields_next = fields;
    ihl         = (pos == POS_IHL) ? frame_byte[3:0] : fields.header_words;
    l4          = POS_IHL + 16'({ihl, 2'b00});
    in_range    = (pos < MAX_POS);

    if (in_range) begin
      if (pos < POS_SRC_MAC) begin
        fields_next.dst_mac = {fields.dst_mac[39:0], frame_byte};
      end else if (pos < POS_ETYPE) begin
        fields_next.src_mac = {fields.src_mac[39:0], frame_byte};
      end else if (pos < POS_IHL) begin
        fields_next.ethertype = {fields.ethertype[7:0], frame_byte};
      end else if (pos == POS_IHL) begin
        fields_next.header_words = frame_byte[3:0];
      end else if (pos == POS_PROTO) begin
        fields_next.protocol = frame_byte;
      end else if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
        fields_next.src_ip = {fields.src_ip[23:0], frame_byte};
      end else if (pos >= POS_DST_IP && pos < POS_IP_END) begin
        fields_next.dst_ip = {fields.dst_ip[23:0], frame_byte};
      end

      if (pos >= l4 && pos < l4 + 16'd2) begin
        fields_next.src_port = {fields.src_port[7:0], frame_byte};
      end else if (pos >= l4 + 16'd2 && pos < l4 + 16'd4) begin
        fields_next.dst_port = {fields.dst_port[7:0], frame_byte};
      end
    end

    len_next = in_range ? pos + 16'd1 : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      fields <= FIELDS_CLEAR;
    end else if (byte_take) begin
      if (last_byte) begin
        pos    <= '0;
        fields <= FIELDS_CLEAR;
      end else begin
        pos    <= len_next;
        fields <= fields_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/eihx_result.sv
`timescale 1ns / 1ps
`default_nettype none

module eihx_result import eihx_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   frame_done,
  input  wire frame_fields_t          fields,
  input  wire logic [15:0]            len,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [RESULT_BITS-1:0]      out_data
);

  logic [15:0] min_seen;
  logic [15:0] max_seen;
  logic [15:0] min_next;
  logic [15:0] max_next;
  logic        ipv4;
  l4_kind_t    kind;
  logic [RESULT_BITS-1:0] data_next;

  always_comb begin
    min_next = (len < min_seen) ? len : min_seen;
    max_next = (len > max_seen) ? len : max_seen;
    ipv4     = (fields.ethertype == ETHERTYPE_IPV4);
    kind     = L4_OTHER;
    if (ipv4) begin
      if (fields.protocol == PROTO_TCP) begin
        kind = L4_TCP;
      end else if (fields.protocol == PROTO_UDP) begin
        kind = L4_UDP;
      end
    end
    data_next = {
      5'd0,
      max_next,
      min_next,
      len,
      (kind != L4_OTHER) ? fields.dst_port : 16'd0,
      (kind != L4_OTHER) ? fields.src_port : 16'd0,
      kind,
      ipv4 ? fields.dst_ip : 32'd0,
      ipv4 ? fields.src_ip : 32'd0,
      ipv4,
      fields.src_mac,
      fields.dst_mac
    };
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      min_seen  <= 16'hFFFF;
      max_seen  <= '0;
    end else begin
      if (frame_done) begin
        out_valid <= 1'b1;
        min_seen  <= min_next;
        max_seen  <= max_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      out_data <= data_next;
    end
  end

  // Held result is self-consistent
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[226:211] <= out_data[242:227])
    else $error("min length above max length");

  a_len_in_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[210:195] >= out_data[226:211] &&
                   out_data[210:195] <= out_data[242:227]))
    else $error("frame length outside running span");

  a_kind_needs_ip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[162:161] != L4_OTHER) |-> out_data[96])
    else $error("transport kind on non-IPv4 frame");

  a_non_ip_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data[96]) |-> (out_data[160:97] == '0 && out_data[194:163] == '0))
    else $error("IP or port fields set on non-IPv4 frame");

  a_stats_on_done: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> out_valid && max_seen >= $past(len) && min_seen <= $past(len))
    else $error("running statistics not updated for finished frame");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import eihx_pkg::*;

  localparam int FRAME_CAP      = 65535;
  localparam int HOLD_CYCLES    = 400;   // long sink hold-off to back up the input
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 10;    // settle margin after the last result
  localparam int PRINT_CAP      = 100;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_t;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          drain;   // wait for every outstanding result before this byte
    bit          hold;    // ask the sink for a long hold-off when this byte goes out
    idle_phase_t phase;
  } byte_item_t;

  // m_tdata layout, MSB first
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] max_length;
    logic [15:0] min_length;
    logic [15:0] frame_length;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    l4_kind_t    l4_kind;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic        is_ipv4;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
  } header_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [RESULT_BITS-1:0] m_tdata;

  eth_ipv4_l4_header_extractor #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_item_t     byte_backlog[$];
  header_result_t expected_headers[$];

  // Shadow of the capture state
  frame_fields_t cap = FIELDS_CLEAR;
  int            cap_pos = 0;
  logic [15:0]   min_seen = 16'hFFFF;
  logic [15:0]   max_seen = 16'h0000;

  int          mismatches = 0;
  int          n_predicted = 0;
  int          n_checked = 0;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  idle_phase_t drv_phase = PH_FREE;

  // Frame builder controls
  idle_phase_t build_phase = PH_FREE;
  bit          drain_next = 1'b0;
  bit          hold_next = 1'b0;

  function automatic int sender_idle(input idle_phase_t p);
    case (p)
      PH_SRC_IDLE: return 79;
      PH_BOTH:     return 38;
      default:     return 0;
    endcase
  endfunction

  function automatic int sink_stall(input idle_phase_t p);
    case (p)
      PH_SNK_STALL: return 79;
      PH_BOTH:      return 38;
      default:      return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Step the shadow state by one accepted byte; queue a header on the last byte
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int             ihl;
    int             l4;
    logic [15:0]    len;
    header_result_t hdr;
    if (cap_pos < FRAME_CAP) begin
      // byte 14 supplies its own IHL for the port offset
      ihl = (cap_pos == POS_IHL) ? int'(b[3:0]) : int'(cap.header_words);
      l4  = 14 + 4 * ihl;
      if (cap_pos < POS_SRC_MAC)
        cap.dst_mac = {cap.dst_mac[39:0], b};
      else if (cap_pos < POS_ETYPE)
        cap.src_mac = {cap.src_mac[39:0], b};
      else if (cap_pos < POS_IHL)
        cap.ethertype = {cap.ethertype[7:0], b};
      else if (cap_pos == POS_IHL)
        cap.header_words = b[3:0];
      else if (cap_pos == POS_PROTO)
        cap.protocol = b;
      else if (cap_pos >= POS_SRC_IP && cap_pos < POS_DST_IP)
        cap.src_ip = {cap.src_ip[23:0], b};
      else if (cap_pos >= POS_DST_IP && cap_pos < POS_IP_END)
        cap.dst_ip = {cap.dst_ip[23:0], b};
      // ports may overlap the IP fields when IHL is small
      if (cap_pos >= l4 && cap_pos < l4 + 2)
        cap.src_port = {cap.src_port[7:0], b};
      else if (cap_pos >= l4 + 2 && cap_pos < l4 + 4)
        cap.dst_port = {cap.dst_port[7:0], b};
      cap_pos++;
    end
    if (last) begin
      len = cap_pos[15:0];
      if (len < min_seen) min_seen = len;
      if (len > max_seen) max_seen = len;
      hdr = '0;
      hdr.dst_mac = cap.dst_mac;
      hdr.src_mac = cap.src_mac;
      hdr.is_ipv4 = (cap.ethertype == ETHERTYPE_IPV4);
      hdr.l4_kind = L4_OTHER;
      if (hdr.is_ipv4) begin
        hdr.src_ip = cap.src_ip;
        hdr.dst_ip = cap.dst_ip;
        if (cap.protocol == PROTO_TCP) hdr.l4_kind = L4_TCP;
        else if (cap.protocol == PROTO_UDP) hdr.l4_kind = L4_UDP;
      end
      if (hdr.l4_kind != L4_OTHER) begin
        hdr.src_port = cap.src_port;
        hdr.dst_port = cap.dst_port;
      end
      hdr.frame_length = len;
      hdr.min_length   = min_seen;
      hdr.max_length   = max_seen;
      expected_headers.push_back(hdr);
      cap     = FIELDS_CLEAR;
      cap_pos = 0;
    end
  endtask

  // Queue one frame; set_hdr forces ethertype, version/IHL and protocol bytes
  task automatic add_frame(input int len, input bit set_hdr, input logic [15:0] etype,
                           input logic [7:0] ver_ihl, input logic [7:0] proto,
                           input fill_t fill);
    byte_item_t it;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (set_hdr) begin
        if (i == POS_ETYPE)          b = etype[15:8];
        else if (i == POS_ETYPE + 1) b = etype[7:0];
        else if (i == POS_IHL)       b = ver_ihl;
        else if (i == POS_PROTO)     b = proto;
      end
      it.data  = b;
      it.last  = (i == len - 1);
      it.drain = (i == 0) && drain_next;
      it.hold  = (i == 0) && hold_next;
      it.phase = build_phase;
      byte_backlog.push_back(it);
    end
    drain_next = 1'b0;
    hold_next  = 1'b0;
  endtask

  // Source side: predict on each transfer, then offer the next byte
  always @(posedge clk) begin : drive_bytes
    byte_item_t it;
    bit         issue;
    int         new_results;
    int         outstanding;
    new_results = 0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_byte(s_tdata, s_tlast);
        if (s_tlast) new_results = 1;
      end
      if (!s_tvalid || s_tready) begin
        issue = 1'b0;
        if (byte_backlog.size() != 0) begin
          it = byte_backlog[0];
          outstanding = n_predicted + new_results - n_checked;
          if (!(it.drain && outstanding != 0))
            issue = ($urandom_range(99) >= sender_idle(it.phase));
        end
        if (issue) begin
          it = byte_backlog.pop_front();
          s_tdata   <= it.data;
          s_tlast   <= it.last;
          s_tvalid  <= 1'b1;
          drv_phase <= it.phase;
          if (it.hold) hold_reqs <= hold_reqs + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      n_predicted <= n_predicted + new_results;
    end
  end

  // Sink side back-pressure, with an occasional long hold-off
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall(drv_phase));
    end
  end

  // Check each result transfer against the oldest expected header
  always @(posedge clk) begin : check_results
    header_result_t got;
    header_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_headers.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(got.frame_length), '0);
      end else begin
        want = expected_headers.pop_front();
        n_checked <= n_checked + 1;
        if (got.dst_mac !== want.dst_mac)
          report_mismatch("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
        if (got.src_mac !== want.src_mac)
          report_mismatch("src_mac", 64'(got.src_mac), 64'(want.src_mac));
        if (got.is_ipv4 !== want.is_ipv4)
          report_mismatch("is_ipv4", 64'(got.is_ipv4), 64'(want.is_ipv4));
        if (got.src_ip !== want.src_ip)
          report_mismatch("src_ip", 64'(got.src_ip), 64'(want.src_ip));
        if (got.dst_ip !== want.dst_ip)
          report_mismatch("dst_ip", 64'(got.dst_ip), 64'(want.dst_ip));
        if (got.l4_kind !== want.l4_kind)
          report_mismatch("l4_kind", 64'(got.l4_kind), 64'(want.l4_kind));
        if (got.src_port !== want.src_port)
          report_mismatch("src_port", 64'(got.src_port), 64'(want.src_port));
        if (got.dst_port !== want.dst_port)
          report_mismatch("dst_port", 64'(got.dst_port), 64'(want.dst_port));
        if (got.frame_length !== want.frame_length)
          report_mismatch("frame_length", 64'(got.frame_length), 64'(want.frame_length));
        if (got.min_length !== want.min_length)
          report_mismatch("min_length", 64'(got.min_length), 64'(want.min_length));
        if (got.max_length !== want.max_length)
          report_mismatch("max_length", 64'(got.max_length), 64'(want.max_length));
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          ihl;
    int          ver;
    int          p;
    int          len;
    int          frames;
    int          phase_start;
    int          idle_cycles;
    bit          timed_out;
    logic [7:0]  proto;
    logic [15:0] etype;

    // Directed frames
    build_phase = PH_FREE;
    add_frame(60, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, FILL_RANDOM);
    add_frame(42, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, FILL_ONES);
    add_frame(42, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, FILL_ZERO);
    add_frame(20, 1'b1, ETHERTYPE_IPV4, 8'h40, PROTO_TCP, FILL_RANDOM);  // IHL 0
    add_frame(24, 1'b1, ETHERTYPE_IPV4, 8'h41, PROTO_UDP, FILL_RANDOM);  // ports over IP
    add_frame(78, 1'b1, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, FILL_RANDOM);  // IHL 15
    add_frame(50, 1'b1, ETHERTYPE_IPV4, 8'h45, 8'd1, FILL_RANDOM);       // other protocol
    add_frame(60, 1'b1, 16'h86DD, 8'h45, PROTO_TCP, FILL_RANDOM);        // not IPv4
    add_frame(40, 1'b1, ETHERTYPE_IPV4, 8'hF5, PROTO_TCP, FILL_RANDOM);  // odd version
    add_frame(1, 1'b0, '0, '0, '0, FILL_ONES);                           // shortest frame
    add_frame(13, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, FILL_RANDOM);  // ethertype cut
    add_frame(14, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, FILL_RANDOM);
    add_frame(33, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, FILL_RANDOM);  // dst_ip cut

    // Long sink hold-off while short frames keep coming
    hold_next = 1'b1;
    for (int k = 0; k < 6; k++)
      add_frame(16, 1'b0, '0, '0, '0, FILL_RANDOM);

    // Random frames, one batch per idling phase
    for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
      build_phase = idle_phase_t'(ph);
      drain_next  = 1'b1;
      phase_start = byte_backlog.size();
      frames      = 0;
      while ((byte_backlog.size() - phase_start) < 190 || frames < 4) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // IPv4 ethertype, mostly version 4 and IHL 5, with both port fields present
          ihl   = ($urandom_range(3) != 0) ? 5 : $urandom_range(15);
          ver   = ($urandom_range(7) != 0) ? 4 : $urandom_range(15);
          p     = $urandom_range(4);
          proto = (p < 2) ? PROTO_TCP : (p < 4) ? PROTO_UDP : 8'($urandom);
          len   = 18 + 4 * ihl + $urandom_range(8);
          add_frame(len, 1'b1, ETHERTYPE_IPV4, {4'(ver), 4'(ihl)}, proto, FILL_RANDOM);
        end else if (r < 82) begin
          // short IPv4 frames of up to 40 bytes with a random version/IHL byte
          proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
          add_frame($urandom_range(1, 40), 1'b1, ETHERTYPE_IPV4, 8'($urandom), proto,
                    FILL_RANDOM);
        end else begin
          // noise, sometimes one bit off the IPv4 ethertype
          etype = $urandom_range(1) ? 16'($urandom)
                                    : ETHERTYPE_IPV4 ^ (16'h1 << $urandom_range(15));
          add_frame($urandom_range(1, 70), 1'b1, etype, 8'($urandom),
                    $urandom_range(1) ? PROTO_TCP : 8'($urandom), FILL_RANDOM);
        end
        frames++;
      end
    end

    // A couple of ordinary frames after a full drain
    build_phase = PH_FREE;
    drain_next  = 1'b1;
    add_frame(10, 1'b0, '0, '0, '0, FILL_RANDOM);
    add_frame(64, 1'b1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, FILL_RANDOM);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge so all rising-edge updates have settled
    idle_cycles = 0;
    timed_out   = 1'b0;
    while (!timed_out &&
           (byte_backlog.size() != 0 || s_tvalid || expected_headers.size() != 0)) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk);

    if (timed_out) begin
      $display("Regression FAIL");
    end else if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
